[hw/rtl/clcd_pkg.sv]
// Shared types, codes and constant tables for the character LCD nibble bus sequencer.
// No dependencies; imported by every module of the block.
package clcd_pkg;

  localparam int COLUMNS   = 16;
  localparam int INIT_CMDS = 7;
  localparam int STEP_W    = 3;
  localparam int QDEPTH    = 4;
  localparam int QPTR_W    = $clog2(QDEPTH);
  localparam int QCNT_W    = $clog2(QDEPTH + 1);

  // Input item kinds.
  localparam logic [2:0] KIND_CMD    = 3'd0;
  localparam logic [2:0] KIND_DATA   = 3'd1;
  localparam logic [2:0] KIND_CURSOR = 3'd2;
  localparam logic [2:0] KIND_INIT   = 3'd3;
  localparam logic [2:0] KIND_BUSY   = 3'd4;

  // Result phases.
  localparam logic [1:0] PHASE_NIBBLE = 2'd0;
  localparam logic [1:0] PHASE_POLL   = 2'd1;
  localparam logic [1:0] PHASE_REFUSE = 2'd2;

  // Wait codes.
  localparam logic [1:0] WAIT_NONE = 2'd0;
  localparam logic [1:0] WAIT_1MS  = 2'd1;
  localparam logic [1:0] WAIT_5MS  = 2'd2;
  localparam logic [1:0] WAIT_50MS = 2'd3;

  // Job codes passed from the front to the back.
  localparam logic [1:0] JOB_REFUSE = 2'd0;
  localparam logic [1:0] JOB_POLL   = 2'd1;
  localparam logic [1:0] JOB_BYTE   = 2'd2;
  localparam logic [1:0] JOB_INIT   = 2'd3;

  // Cursor row bases.
  localparam logic [7:0] ROW1_BASE = 8'h80;
  localparam logic [7:0] ROW2_BASE = 8'hC0;
  localparam logic [7:0] ROW3_BASE = 8'(8'h80 + COLUMNS);
  localparam logic [7:0] ROW4_BASE = 8'(8'hC0 + COLUMNS);

  localparam logic [3:0] NIB_RELEASE = 4'hF;

  typedef struct packed {
    logic [1:0]        code;
    logic              rs;
    logic [7:0]        data;
    logic              poll;
    logic              wake;
    logic [STEP_W-1:0] start;
    logic [STEP_W-1:0] count;
    logic [1:0]        first_wait;
  } job_t;

  function automatic logic [7:0] init_cmd(input logic [STEP_W-1:0] idx);
    logic [7:0] v;
    case (idx)
      3'd0:    v = 8'h28;
      3'd1:    v = 8'h01;
      3'd2:    v = 8'h08;
      3'd3:    v = 8'h0C;
      3'd4:    v = 8'h06;
      3'd5:    v = 8'h0F;
      3'd6:    v = 8'h01;
      default: v = 8'h01;
    endcase
    return v;
  endfunction

  function automatic logic [3:0] wake_nib(input logic [1:0] idx);
    return (idx == 2'd3) ? 4'h2 : 4'h3;
  endfunction

  function automatic logic [1:0] wake_wait(input logic [1:0] idx);
    logic [1:0] v;
    case (idx)
      2'd0:    v = WAIT_50MS;
      2'd1:    v = WAIT_5MS;
      default: v = WAIT_1MS;
    endcase
    return v;
  endfunction

endpackage

[hw/rtl/clcd_front.sv]
// Front end: accepts input beats, tracks poll and init state, and emits at most one job per beat.
// Depends on clcd_pkg.
module clcd_front
  import clcd_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_write,
  input  logic        cfg_data,
  input  logic        accept,
  input  logic [2:0]  kind,
  input  logic [7:0]  byte_value,
  input  logic [2:0]  row,
  input  logic [4:0]  column,
  input  logic        busy_level,
  output logic        push,
  output job_t        job
);

  logic              skip;
  logic              poll_pending, poll_pending_next;
  logic              init_active, init_active_next;
  logic [STEP_W-1:0] init_step, init_step_next;

  logic [7:0]        col8, colc, base, cursor_byte;
  logic              row_ok;
  logic [STEP_W-1:0] cnt;
  logic [STEP_W:0]   step_end;

  always_comb begin
    col8 = {3'b000, column};
    if (col8 == 8'd0) begin
      colc = 8'd1;
    end else if (col8 > 8'(COLUMNS)) begin
      colc = 8'(COLUMNS);
    end else begin
      colc = col8;
    end
    row_ok = 1'b1;
    case (row)
      3'd1:    base = ROW1_BASE;
      3'd2:    base = ROW2_BASE;
      3'd3:    base = ROW3_BASE;
      3'd4:    base = ROW4_BASE;
      default: begin
        base   = ROW1_BASE;
        row_ok = 1'b0;
      end
    endcase
    cursor_byte = base + colc - 8'd1;
  end

  always_comb begin
    push              = 1'b0;
    job               = '0;
    poll_pending_next = poll_pending;
    init_active_next  = init_active;
    init_step_next    = init_step;
    cnt               = skip ? STEP_W'(INIT_CMDS) - init_step : STEP_W'(1);
    step_end          = {1'b0, init_step} + {1'b0, cnt};
    if (accept) begin
      if (poll_pending && kind != KIND_BUSY) begin
        push     = 1'b1;
        job.code = JOB_REFUSE;
      end else begin
        case (kind)
          KIND_CMD, KIND_DATA: begin
            push              = 1'b1;
            job.code          = JOB_BYTE;
            job.rs            = (kind == KIND_DATA);
            job.data          = byte_value;
            job.poll          = !skip;
            poll_pending_next = !skip;
          end
          KIND_CURSOR: begin
            if (row_ok) begin
              push              = 1'b1;
              job.code          = JOB_BYTE;
              job.data          = cursor_byte;
              job.poll          = !skip;
              poll_pending_next = !skip;
            end
          end
          KIND_INIT: begin
            push              = 1'b1;
            job.code          = JOB_INIT;
            job.wake          = 1'b1;
            job.start         = '0;
            job.count         = skip ? STEP_W'(INIT_CMDS) : STEP_W'(1);
            job.poll          = !skip;
            job.first_wait    = WAIT_1MS;
            init_step_next    = job.count;
            init_active_next  = (job.count < STEP_W'(INIT_CMDS));
            poll_pending_next = !skip;
          end
          KIND_BUSY: begin
            if (poll_pending) begin
              if (busy_level) begin
                push     = 1'b1;
                job.code = JOB_POLL;
              end else begin
                poll_pending_next = 1'b0;
                if (init_active) begin
                  if (init_step < STEP_W'(INIT_CMDS)) begin
                    // Released poll during init: next command, or all the rest when skipping.
                    push              = 1'b1;
                    job.code          = JOB_INIT;
                    job.start         = init_step;
                    job.count         = cnt;
                    job.poll          = !skip;
                    job.first_wait    = WAIT_NONE;
                    init_step_next    = step_end[STEP_W-1:0];
                    init_active_next  = (step_end < (STEP_W + 1)'(INIT_CMDS));
                    poll_pending_next = !skip;
                  end else begin
                    init_active_next = 1'b0;
                  end
                end
              end
            end
          end
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      skip         <= 1'b0;
      poll_pending <= 1'b0;
      init_active  <= 1'b0;
      init_step    <= '0;
    end else begin
      if (cfg_write) begin
        skip <= cfg_data;
      end
      poll_pending <= poll_pending_next;
      init_active  <= init_active_next;
      init_step    <= init_step_next;
    end
  end

endmodule

[hw/rtl/clcd_queue.sv]
// Short job queue between the front and back ends.
// Depends on clcd_pkg for the job type and depth.
module clcd_queue
  import clcd_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  job_t wr_job,
  input  logic pop,
  output job_t rd_job,
  output logic not_empty,
  output logic full
);

  job_t              slots [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr, rd_ptr;
  logic [QCNT_W-1:0] count;

  assign full      = (count == QCNT_W'(QDEPTH));
  assign not_empty = (count != '0);
  assign rd_job    = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= wr_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + QPTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + QPTR_W'(1);
      end
      count <= count + QCNT_W'(push) - QCNT_W'(pop);
    end
  end

endmodule

[hw/rtl/clcd_back.sv]
// Back end: expands queued jobs into bus phase beats, one per cycle while out_stall allows, into an output register.
// Depends on clcd_pkg.
module clcd_back
  import clcd_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       q_valid,
  input  job_t       q_job,
  output logic       q_pop,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [1:0] phase,
  output logic       reg_select,
  output logic [3:0] nibble,
  output logic [1:0] wait_before,
  output logic       long_strobe,
  output logic       last
);

  localparam logic [2:0] ST_WAKE = 3'd0;
  localparam logic [2:0] ST_HI   = 3'd1;
  localparam logic [2:0] ST_LO   = 3'd2;
  localparam logic [2:0] ST_POLL = 3'd3;
  localparam logic [2:0] ST_REF  = 3'd4;

  logic              active;
  job_t              cur;
  logic [2:0]        stage;
  logic [1:0]        wcnt;
  logic [STEP_W-1:0] idx;
  logic [STEP_W-1:0] rem;
  logic              first;

  logic       emit, is_last;
  logic [7:0] cur_byte;
  logic [1:0] e_phase, e_wait;
  logic       e_rs, e_long;
  logic [3:0] e_nib;

  assign emit     = active && (!out_valid || !out_stall);
  assign cur_byte = (cur.code == JOB_BYTE) ? cur.data : init_cmd(idx);
  assign q_pop    = q_valid && (!active || (emit && is_last));

  always_comb begin
    e_phase = PHASE_NIBBLE;
    e_rs    = 1'b0;
    e_nib   = 4'h0;
    e_wait  = WAIT_NONE;
    e_long  = 1'b0;
    is_last = 1'b0;
    case (stage)
      ST_WAKE: begin
        e_nib  = wake_nib(wcnt);
        e_wait = wake_wait(wcnt);
        e_long = 1'b1;
      end
      ST_HI: begin
        e_rs   = cur.rs;
        e_nib  = cur_byte[7:4];
        e_wait = first ? cur.first_wait : WAIT_NONE;
      end
      ST_LO: begin
        e_rs    = cur.rs;
        e_nib   = cur_byte[3:0];
        is_last = !cur.poll && (rem == STEP_W'(1));
      end
      ST_POLL: begin
        e_phase = PHASE_POLL;
        e_nib   = NIB_RELEASE;
        is_last = (rem == STEP_W'(1));
      end
      ST_REF: begin
        e_phase = PHASE_REFUSE;
        is_last = 1'b1;
      end
      default: begin
        is_last = 1'b1;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
    end else if (q_pop) begin
      active <= 1'b1;
    end else if (emit && is_last) begin
      active <= 1'b0;
    end
  end

  // Job sequencing registers; the active flag above qualifies them.
  always_ff @(posedge clk) begin
    if (q_pop) begin
      cur   <= q_job;
      wcnt  <= 2'd0;
      first <= 1'b1;
      idx   <= (q_job.code == JOB_INIT) ? q_job.start : '0;
      rem   <= (q_job.code == JOB_INIT) ? q_job.count : STEP_W'(1);
      case (q_job.code)
        JOB_REFUSE: stage <= ST_REF;
        JOB_POLL:   stage <= ST_POLL;
        JOB_BYTE:   stage <= ST_HI;
        default:    stage <= q_job.wake ? ST_WAKE : ST_HI;
      endcase
    end else if (emit) begin
      case (stage)
        ST_WAKE: begin
          if (wcnt == 2'd3) begin
            stage <= ST_HI;
          end
          wcnt <= wcnt + 2'd1;
        end
        ST_HI: begin
          stage <= ST_LO;
          first <= 1'b0;
        end
        ST_LO, ST_POLL: begin
          if (stage == ST_LO && cur.poll) begin
            stage <= ST_POLL;
          end else begin
            stage <= ST_HI;
            idx   <= idx + STEP_W'(1);
            rem   <= rem - STEP_W'(1);
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      phase       <= e_phase;
      reg_select  <= e_rs;
      nibble      <= e_nib;
      wait_before <= e_wait;
      long_strobe <= e_long;
      last        <= is_last;
    end
  end

endmodule

[hw/rtl/char_lcd_nibble_bus_sequencer.sv]
// Top level of the character LCD nibble bus sequencer: front end, job queue, back end.
// Depends on clcd_pkg, clcd_front, clcd_queue and clcd_back.
//
//   Channel   Signals                                        Direction
//   config    cfg_write, cfg_data                            in
//   item      in_valid, in_stall, kind..busy_level           in (stall out)
//   phase     out_valid, out_stall, phase..last              out (stall in)
//
// An item is taken whenever the four-entry job queue has room.
// The back end sends one phase beat per cycle while out_stall is low: two for a byte, three with a poll,
// up to eighteen for an init; a queued next job is popped in the same cycle as the last beat.
// Reset is synchronous and clears the poll, init and skip state and the queue.
// in_stall is high only while the job queue is full; out_stall holds the output register.
module char_lcd_nibble_bus_sequencer
  import clcd_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_write,
  input  logic       cfg_data,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [2:0] kind,
  input  logic [7:0] byte_value,
  input  logic [2:0] row,
  input  logic [4:0] column,
  input  logic       busy_level,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [1:0] phase,
  output logic       reg_select,
  output logic [3:0] nibble,
  output logic [1:0] wait_before,
  output logic       long_strobe,
  output logic       last
);

  logic accept, q_push, q_pop, q_valid, q_full;
  job_t wr_job, rd_job;

  assign in_stall = q_full;
  assign accept   = in_valid && !in_stall;

  clcd_front u_front (
    .clk        (clk),
    .rst        (rst),
    .cfg_write  (cfg_write),
    .cfg_data   (cfg_data),
    .accept     (accept),
    .kind       (kind),
    .byte_value (byte_value),
    .row        (row),
    .column     (column),
    .busy_level (busy_level),
    .push       (q_push),
    .job        (wr_job)
  );

  clcd_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .wr_job    (wr_job),
    .pop       (q_pop),
    .rd_job    (rd_job),
    .not_empty (q_valid),
    .full      (q_full)
  );

  clcd_back u_back (
    .clk         (clk),
    .rst         (rst),
    .q_valid     (q_valid),
    .q_job       (rd_job),
    .q_pop       (q_pop),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .phase       (phase),
    .reg_select  (reg_select),
    .nibble      (nibble),
    .wait_before (wait_before),
    .long_strobe (long_strobe),
    .last        (last)
  );

`ifndef SYNTHESIS
  // The front never pushes a job into a full queue.
  assert property (@(posedge clk) disable iff (rst) q_push |-> !q_full)
    else $error("job pushed into full queue");

  // A refused beat always closes its item.
  assert property (@(posedge clk) disable iff (rst)
    (out_valid && phase == PHASE_REFUSE) |-> last)
    else $error("refused beat not marked last");

  // Long strobes appear only on wake-up nibble writes, which always carry a wait.
  assert property (@(posedge clk) disable iff (rst)
    (out_valid && long_strobe) |-> (phase == PHASE_NIBBLE && wait_before != WAIT_NONE))
    else $error("long strobe on a non wake-up beat");
`endif

endmodule
